>>> rtl/sfct_pkg.sv
// Shared types, constants and the CRC-8 step for the sensor frame checker.
// Depends on nothing; every other design and testbench file but sfct_if imports it.
package sfct_pkg;

    localparam int LONG_FRAME_BYTES  = 7;
    localparam int SHORT_FRAME_BYTES = 5;

    localparam int IDX_W     = 3;
    localparam int RAW_W     = 20;
    localparam int SHORT_W   = 16;
    localparam int TEMP_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [IDX_W-1:0] IDLE_INDEX = 3'd7;
    localparam logic [IDX_W-1:0] LONG_LAST  = IDX_W'(LONG_FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] SHORT_LAST = IDX_W'(SHORT_FRAME_BYTES - 1);

    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] POLY_RESET = 8'h31;
    localparam logic [7:0] BUSY_MASK  = 8'h80;
    localparam logic [3:0] RAW_HI_MASK = 4'hF;
    localparam logic [SHORT_W-1:0] RAW_INVALID = 16'hFFFF;

    // Conversion constants for the two sensor kinds
    localparam logic [14:0] LONG_SCALE  = 15'd1250;
    localparam logic [14:0] SHORT_SCALE = 15'd17500;
    localparam logic signed [16:0] LONG_BIAS  = 17'sd5000;
    localparam logic signed [16:0] SHORT_BIAS = 17'sd4500;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sh8000;

    typedef enum logic {
        KIND_LONG  = 1'b0,
        KIND_SHORT = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC     = 2'd1,
        ST_BUSY    = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRC_POLY = 2'd0,
        CFG_OFFSET   = 2'd1
    } cfg_index_t;

    // Finished frame handed from the frame tracker to the converter
    typedef struct packed {
        logic [RAW_W-1:0] raw;
        kind_t            kind;
        status_t          status;
    } frame_res_t;

    // One byte through the CRC-8, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ poly;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> rtl/sfct_if.sv
// Valid/ready channel interfaces: received bytes, results and register writes.
// Depends on no other file; field widths are written out as literals.
interface sfct_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       sensor_kind;

    modport source (output valid, rx_byte, frame_start, sensor_kind, input ready);
    modport sink   (input valid, rx_byte, frame_start, sensor_kind, output ready);
endinterface

interface sfct_tx_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature;
    logic [1:0]         status;
    logic               kind_out;

    modport source (output valid, temperature, status, kind_out, input ready);
    modport sink   (input valid, temperature, status, kind_out, output ready);
endinterface

interface sfct_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/sfct_frame.sv
// Frame tracker: byte counter, running CRC, raw temperature and error flags.
// Depends on sfct_pkg for the CRC step and the frame result type.
module sfct_frame (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic [7:0]             rx_byte,
    input  logic                   frame_start,
    input  logic                   sensor_kind,
    input  logic [7:0]             crc_poly,
    output logic                   done,
    output sfct_pkg::frame_res_t   res
);
    import sfct_pkg::*;

    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [7:0]       crc_reg, crc_next;
    logic [RAW_W-1:0] raw_reg, raw_next;
    logic             busy_reg, busy_next;
    logic             matched_reg, matched_next;
    kind_t            kind_reg, kind_next;

    logic [IDX_W-1:0] idx;
    logic [7:0]       crc_cur;
    logic [RAW_W-1:0] raw_cur;
    logic             busy_cur;
    logic             matched_cur;
    kind_t            kind_cur;
    logic [7:0]       crc_step;

    // Frame start restarts the frame with this word as byte 0
    always_comb
    begin
        if (frame_start)
        begin
            idx         = '0;
            crc_cur     = CRC_INIT;
            raw_cur     = '0;
            busy_cur    = 1'b0;
            matched_cur = 1'b0;
            kind_cur    = kind_t'(sensor_kind);
        end
        else
        begin
            idx         = byte_index_reg;
            crc_cur     = crc_reg;
            raw_cur     = raw_reg;
            busy_cur    = busy_reg;
            matched_cur = matched_reg;
            kind_cur    = kind_reg;
        end
    end

    assign crc_step = crc8_byte(crc_cur, rx_byte, crc_poly);

    always_comb
    begin
        byte_index_next = idx;
        crc_next        = crc_cur;
        raw_next        = raw_cur;
        busy_next       = busy_cur;
        matched_next    = matched_cur;
        kind_next       = kind_cur;
        done            = 1'b0;
        res.raw         = '0;
        res.kind        = kind_cur;
        res.status      = ST_OK;

        if (idx != IDLE_INDEX)
        begin
            if (kind_cur == KIND_LONG)
            begin
                crc_next = crc_step;
                case (idx)
                    3'd0:    busy_next = (rx_byte & BUSY_MASK) != 8'd0;
                    3'd3:    raw_next  = {rx_byte[3:0] & RAW_HI_MASK, 16'd0};
                    3'd4:    raw_next  = {raw_cur[19:16], rx_byte, raw_cur[7:0]};
                    3'd5:    raw_next  = {raw_cur[19:8], rx_byte};
                    default: raw_next  = raw_cur;
                endcase
                if (idx == LONG_LAST)
                begin
                    byte_index_next = IDLE_INDEX;
                    done            = 1'b1;
                    res.raw         = raw_next;
                    if (busy_next)
                        res.status = ST_BUSY;
                    else if (crc_next != 8'd0)
                        res.status = ST_CRC;
                    else
                        res.status = ST_OK;
                end
                else
                begin
                    byte_index_next = idx + 1'b1;
                end
            end
            else
            begin
                case (idx)
                    3'd0:
                    begin
                        crc_next = crc_step;
                        raw_next = {4'd0, rx_byte, 8'd0};
                    end
                    3'd1:
                    begin
                        crc_next = crc_step;
                        raw_next = {4'd0, raw_cur[15:8], rx_byte};
                    end
                    3'd2:    matched_next = (crc_cur == rx_byte);
                    default: raw_next     = raw_cur;
                endcase
                if (idx == SHORT_LAST)
                begin
                    byte_index_next = IDLE_INDEX;
                    done            = 1'b1;
                    res.raw         = raw_next;
                    if (!matched_next)
                        res.status = ST_CRC;
                    else if (raw_next[SHORT_W-1:0] == RAW_INVALID)
                        res.status = ST_INVALID;
                    else
                        res.status = ST_OK;
                end
                else
                begin
                    byte_index_next = idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            crc_reg        <= CRC_INIT;
            raw_reg        <= '0;
            busy_reg       <= 1'b0;
            matched_reg    <= 1'b0;
            kind_reg       <= KIND_LONG;
        end
        else if (take)
        begin
            byte_index_reg <= byte_index_next;
            crc_reg        <= crc_next;
            raw_reg        <= raw_next;
            busy_reg       <= busy_next;
            matched_reg    <= matched_next;
            kind_reg       <= kind_next;
        end
    end

endmodule

>>> rtl/sfct_conv.sv
// Temperature conversion: scale raw reading, remove bias, add offset, saturate; zero on bad status.
// Depends on sfct_pkg for the frame result type and conversion constants.
module sfct_conv (
    input  sfct_pkg::frame_res_t        res,
    input  logic signed [15:0]          offset,
    output logic signed [15:0]          temperature
);
    import sfct_pkg::*;

    logic [RAW_W-1:0]        mul_a;
    logic [14:0]             mul_b;
    logic [RAW_W+14:0]       product;
    logic signed [16:0]      bias;
    logic signed [17:0]      sum;

    always_comb
    begin
        if (res.kind == KIND_SHORT)
        begin
            mul_a = {4'd0, res.raw[SHORT_W-1:0]};
            mul_b = SHORT_SCALE;
            bias  = SHORT_BIAS;
        end
        else
        begin
            mul_a = res.raw;
            mul_b = LONG_SCALE;
            bias  = LONG_BIAS;
        end
    end

    assign product = mul_a * mul_b;

    // Scaled value stays below 2^15, so bits 31:16 hold it
    assign sum = 18'(signed'({2'b00, product[31:16]})) - 18'(bias) + 18'(offset);

    always_comb
    begin
        if (res.status != ST_OK)
            temperature = '0;
        else if (sum > 18'(TEMP_MAX))
            temperature = TEMP_MAX;
        else if (sum < 18'(TEMP_MIN))
            temperature = TEMP_MIN;
        else
            temperature = sum[15:0];
    end

endmodule

>>> rtl/sensor_frame_crc_temperature_top.sv
// Top level of the sensor frame checker: channels, registers and result pipeline.
// Depends on sfct_pkg, sfct_if, sfct_frame and sfct_conv.
//
//   channel | dir | payload                              | words
//   rx      | in  | rx_byte, frame_start, sensor_kind    | one received byte
//   tx      | out | temperature, status, kind_out        | one per finished frame
//   cfg     | in  | index (0 crc_poly, 1 offset), data   | one register write
//
// One byte is taken every cycle while rx is ready. After the last byte of a frame,
// the frame tracker fills a stage register with its result and the converter (one
// 20x15 multiply plus add and saturate) fills the output register that drives tx.
// Reset gives crc_poly 0x31, offset 0 and an empty pipeline.
// rx stalls only when both result registers are full and tx is not ready.
module sensor_frame_crc_temperature_top (
    input  logic        clk,
    input  logic        rst_n,
    sfct_rx_if.sink     rx,
    sfct_tx_if.source   tx,
    sfct_cfg_if.sink    cfg
);
    import sfct_pkg::*;

    logic [7:0]         poly_reg;
    logic signed [15:0] offset_reg;

    logic               stage_valid_reg, stage_valid_next;
    frame_res_t         stage_reg;
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] temp_reg;
    status_t            status_reg;
    kind_t              kind_reg;

    logic               take;
    logic               out_adv;
    logic               done;
    frame_res_t         frame_res;
    logic signed [15:0] conv_temp;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg   <= POLY_RESET;
            offset_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_CRC_POLY: poly_reg   <= cfg.data[7:0];
                CFG_OFFSET:   offset_reg <= cfg.data;
                default:      poly_reg   <= poly_reg;
            endcase
        end
    end

    // Advance the output register when empty or drained
    assign out_adv  = !out_valid_reg || tx.ready;
    assign rx.ready = !stage_valid_reg || out_adv;
    assign take     = rx.valid && rx.ready;

    sfct_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .rx_byte     (rx.rx_byte),
        .frame_start (rx.frame_start),
        .sensor_kind (rx.sensor_kind),
        .crc_poly    (poly_reg),
        .done        (done),
        .res         (frame_res)
    );

    sfct_conv u_conv (
        .res         (stage_reg),
        .offset      (offset_reg),
        .temperature (conv_temp)
    );

    always_comb
    begin
        if (take && done)
            stage_valid_next = 1'b1;
        else if (out_adv)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
        out_valid_next = out_adv ? stage_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && done)
            stage_reg <= frame_res;
        if (out_adv && stage_valid_reg)
        begin
            temp_reg   <= conv_temp;
            status_reg <= stage_reg.status;
            kind_reg   <= stage_reg.kind;
        end
    end

    assign tx.valid       = out_valid_reg;
    assign tx.temperature = temp_reg;
    assign tx.status      = status_reg;
    assign tx.kind_out    = kind_reg;

endmodule

>>> tb/sensor_frame_crc_temperature_checker.sv
// Result checker for the sensor frame checker: predicts one reading per finished frame
// from the accepted byte words and compares it with each word taken from tx.
// Depends on sfct_pkg and the channel interfaces in sfct_if.
module sensor_frame_crc_temperature_checker (
    input  logic clk,
    input  logic rst_n,
    sfct_rx_if   rx,
    sfct_tx_if   tx,
    sfct_cfg_if  cfg,
    output int   mismatches,
    output int   readings_owed
);
    import sfct_pkg::*;

    typedef struct {
        logic signed [15:0] temperature;
        status_t            status;
        kind_t              kind;
    } reading_t;

    reading_t readings_due[$];

    // Register copies
    logic [7:0]         poly;
    logic signed [15:0] offset;

    // Frame tracking
    logic [2:0]  pos;
    logic [7:0]  crc_run;
    logic [19:0] raw;
    logic        busy_flag;
    logic        crc_ok;
    kind_t       cur_kind;

    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b,
                                             input logic [7:0] gen);
        logic [7:0] c;
        logic       fb;
        c = acc ^ b;
        repeat (8)
        begin
            fb = c[7];
            c  = c << 1;
            if (fb)
                c = c ^ gen;
        end
        return c;
    endfunction

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatches++;
        $display("mismatch %0s: got %0d expected %0d at %0t", field, got, want, $time);
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic start, input kind_t k);
        reading_t    r;
        int          deg;
        logic [31:0] scaled;
        status_t     st;
        if (start)
        begin
            pos       = '0;
            crc_run   = 8'hFF;
            raw       = '0;
            busy_flag = 1'b0;
            crc_ok    = 1'b0;
            cur_kind  = k;
        end
        // finished frame: drop bytes until the next frame start
        if (pos == IDLE_INDEX)
            return;
        if (cur_kind == KIND_LONG)
        begin
            crc_run = crc8_next(crc_run, b, poly);
            case (pos)
                3'd0: busy_flag = b[7];
                3'd3: raw = {b[3:0], 16'h0000};
                3'd4: raw[15:8] = b;
                3'd5: raw[7:0] = b;
                default: ;
            endcase
            if (pos != LONG_LAST)
            begin
                pos = pos + 3'd1;
                return;
            end
            if (busy_flag)
                st = ST_BUSY;
            else if (crc_run != 8'h00)
                st = ST_CRC;
            else
                st = ST_OK;
            scaled = 32'(raw) * 32'd1250;
            deg    = int'(scaled >> 16) - 5000;
        end
        else
        begin
            // bytes after the check byte advance the position and nothing else
            case (pos)
                3'd0:
                begin
                    crc_run = crc8_next(crc_run, b, poly);
                    raw     = {4'h0, b, 8'h00};
                end
                3'd1:
                begin
                    crc_run  = crc8_next(crc_run, b, poly);
                    raw[7:0] = b;
                end
                3'd2: crc_ok = (crc_run == b);
                default: ;
            endcase
            if (pos != SHORT_LAST)
            begin
                pos = pos + 3'd1;
                return;
            end
            if (!crc_ok)
                st = ST_CRC;
            else if (raw[15:0] == RAW_INVALID)
                st = ST_INVALID;
            else
                st = ST_OK;
            scaled = 32'(raw[15:0]) * 32'd17500;
            deg    = int'(scaled >> 16) - 4500;
        end
        pos = IDLE_INDEX;
        r.temperature = (st == ST_OK) ? clamp16(deg + int'(offset)) : 16'sh0000;
        r.status      = st;
        r.kind        = cur_kind;
        readings_due.push_back(r);
    endtask

    task automatic check_reading();
        reading_t want;
        if (readings_due.size() == 0)
        begin
            report_mismatch("reading with none due, temperature", int'(tx.temperature), 0);
            return;
        end
        want = readings_due.pop_front();
        if (tx.temperature !== want.temperature)
            report_mismatch("temperature", int'(tx.temperature), int'(want.temperature));
        if (tx.status !== want.status)
            report_mismatch("status", int'(tx.status), int'(want.status));
        if (tx.kind_out !== want.kind)
            report_mismatch("kind_out", int'(tx.kind_out), int'(want.kind));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly          = POLY_RESET;
            offset        = '0;
            pos           = '0;
            crc_run       = 8'hFF;
            raw           = '0;
            busy_flag     = 1'b0;
            crc_ok        = 1'b0;
            cur_kind      = KIND_LONG;
            mismatches    = 0;
            readings_due.delete();
            readings_owed = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_CRC_POLY: poly = cfg.data[7:0];
                    CFG_OFFSET:   offset = cfg.data;
                    default: ;
                endcase
            end
            if (tx.valid && tx.ready)
                check_reading();
            if (rx.valid && rx.ready)
                absorb_byte(rx.rx_byte, rx.frame_start, kind_t'(rx.sensor_kind));
            readings_owed = readings_due.size();
        end
    end

endmodule

>>> tb/sensor_frame_crc_temperature_top_tb.sv
// Testbench top for the sensor frame checker: clock, reset, byte and register stimulus,
// result back-pressure and the verdict. Depends on sfct_pkg, sfct_if, the block and
// sensor_frame_crc_temperature_checker.
module sensor_frame_crc_temperature_top_tb;
    import sfct_pkg::*;

    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASES        = 6;
    localparam int PHASE_BYTES   = 210;

    logic clk = 1'b0;
    logic rst_n;

    int   mismatches;
    int   readings_owed;
    int   quiet_cycles;

    bit         rx_gaps_on   = 1'b1;
    bit         tx_stalls_on = 1'b1;
    bit         tx_hold_req  = 1'b0;
    logic [7:0] poly_now     = POLY_RESET;

    sfct_rx_if  rx_ch ();
    sfct_tx_if  tx_ch ();
    sfct_cfg_if cfg_ch ();

    sensor_frame_crc_temperature_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch),
        .cfg   (cfg_ch)
    );

    sensor_frame_crc_temperature_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx_ch),
        .tx            (tx_ch),
        .cfg           (cfg_ch),
        .mismatches    (mismatches),
        .readings_owed (readings_owed)
    );

    always #2 clk = ~clk;

    // Stop a hung run: count cycles in which no channel moves a word
    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Frame builder CRC, used to make well-formed check bytes
    function automatic logic [7:0] crc8_of(input logic [7:0] acc, input logic [7:0] b,
                                           input logic [7:0] gen);
        logic [7:0] c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++)
            c = c[7] ? ((c << 1) ^ gen) : (c << 1);
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic start, input logic kind);
        int gap;
        gap = rx_gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid       <= 1'b1;
        rx_ch.rx_byte     <= b;
        rx_ch.frame_start <= start;
        rx_ch.sensor_kind <= kind;
        do @(posedge clk); while (!rx_ch.ready);
    endtask

    // Hold the byte channel until every reading due has come, then let the pipe settle
    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        do @(negedge clk); while (readings_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Build a frame with a matching check byte, spoil one byte if asked, send n_send words
    task automatic send_frame(input kind_t k, input logic busy, input logic [19:0] raw,
                              input int spoil_at, input int n_send, input logic with_start);
        logic [7:0] frame_bytes [7];
        logic [7:0] c;
        int         i;
        for (i = 0; i < 7; i++)
            frame_bytes[i] = 8'($urandom);
        if (k == KIND_LONG)
        begin
            frame_bytes[0][7] = busy;
            frame_bytes[3]    = {frame_bytes[3][7:4], raw[19:16]};
            frame_bytes[4]    = raw[15:8];
            frame_bytes[5]    = raw[7:0];
            c = 8'hFF;
            for (i = 0; i < 6; i++)
                c = crc8_of(c, frame_bytes[i], poly_now);
            frame_bytes[6] = c;
        end
        else
        begin
            frame_bytes[0] = raw[15:8];
            frame_bytes[1] = raw[7:0];
            frame_bytes[2] = crc8_of(crc8_of(8'hFF, raw[15:8], poly_now), raw[7:0], poly_now);
        end
        if (spoil_at >= 0)
            frame_bytes[spoil_at] ^= 8'($urandom_range(1, 255));
        for (i = 0; i < n_send; i++)
        begin
            if (i == 0)
                push_byte(frame_bytes[i], with_start, k);
            else
                push_byte(frame_bytes[i], 1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic random_frame(output int counted);
        kind_t       k;
        logic [19:0] raw;
        logic        busy;
        int          len;
        int          n_send;
        int          spoil;
        int          pick;
        int          i;
        k    = kind_t'(1'($urandom_range(0, 1)));
        len  = (k == KIND_LONG) ? LONG_FRAME_BYTES : SHORT_FRAME_BYTES;
        busy = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 7))
            0: raw = 20'h00000;
            1: raw = (k == KIND_LONG) ? 20'hFFFFF : 20'h0FFFF;
            2: raw = (k == KIND_LONG) ? 20'hFFFFE : 20'h0FFFE;
            default: raw = 20'($urandom);
        endcase
        if (k == KIND_SHORT)
            raw[19:16] = 4'h0;
        spoil  = -1;
        n_send = len;
        pick   = $urandom_range(0, 99);
        if (pick >= 93)
        begin
            // noise: loose bytes, some of which open frames that may never finish
            for (i = $urandom_range(1, 6); i > 0; i--)
                push_byte(8'($urandom), ($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)));
            counted = 0;
            return;
        end
        if (pick >= 85)
            n_send = $urandom_range(1, len - 1);
        else if (pick >= 75)
            spoil = $urandom_range(0, len - 1);
        send_frame(k, busy, raw, spoil, n_send, 1'b1);
        counted = n_send;
    endtask

    // Result side: random stalls, one long hold on request
    initial
    begin
        int stall;
        tx_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (tx_hold_req)
            begin
                tx_hold_req = 1'b0;
                tx_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = tx_stalls_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                tx_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            tx_ch.ready <= 1'b1;
            do @(posedge clk); while (!tx_ch.valid);
        end
    end

    initial
    begin
        int          ph;
        int          sent;
        int          n;
        bit          paused;
        logic [15:0] offset_now;
        rst_n              <= 1'b0;
        rx_ch.valid        <= 1'b0;
        rx_ch.rx_byte      <= '0;
        rx_ch.frame_start  <= 1'b0;
        rx_ch.sensor_kind  <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_CRC_POLY;
        cfg_ch.data        <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: first frame after reset has no start flag and the top raw value
        send_frame(KIND_LONG, 1'b0, 20'hFFFFF, -1, LONG_FRAME_BYTES, 1'b0);
        // bad check byte on an invalid reading: CRC error wins
        send_frame(KIND_SHORT, 1'b0, 20'h0FFFF, 2, SHORT_FRAME_BYTES, 1'b1);
        // cut a frame short with a new start, then busy with a bad check byte
        send_frame(KIND_SHORT, 1'b0, 20'h01234, -1, 2, 1'b1);
        send_frame(KIND_LONG, 1'b1, 20'h00000, 6, LONG_FRAME_BYTES, 1'b1);
        // stray words after a finished frame
        push_byte(8'hA5, 1'b0, 1'b1);
        push_byte(8'h5A, 1'b0, 1'b0);
        send_frame(KIND_SHORT, 1'b0, 20'h0FFFF, -1, SHORT_FRAME_BYTES, 1'b1);

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    poly_now   = POLY_RESET;
                    offset_now = 16'h0000;
                end
                1:
                begin
                    poly_now   = 8'h00;
                    offset_now = 16'h7FFF;
                end
                2:
                begin
                    poly_now   = 8'hFF;
                    offset_now = 16'h8000;
                end
                3:
                begin
                    poly_now   = 8'h07;
                    offset_now = 16'($urandom);
                end
                4:
                begin
                    poly_now   = 8'($urandom);
                    offset_now = 16'($urandom);
                end
                default:
                begin
                    poly_now   = POLY_RESET;
                    offset_now = 16'(int'($urandom_range(0, 1000)) - 500);
                end
            endcase
            write_reg(CFG_CRC_POLY, {8'h00, poly_now});
            write_reg(CFG_OFFSET, offset_now);
            rx_gaps_on   = (ph % 3 != 1);
            tx_stalls_on = (ph % 3 != 2);
            // back-pressure the results long enough to stall the byte channel
            if (ph == 1)
                tx_hold_req = 1'b1;
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_BYTES)
            begin
                random_frame(n);
                sent += n;
                if (ph == 3 && !paused && sent >= PHASE_BYTES / 2)
                begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
        end

        wait_drained();
        if (mismatches == 0 && readings_owed == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
rtl/sfct_pkg.sv
rtl/sfct_if.sv
rtl/sfct_frame.sv
rtl/sfct_conv.sv
rtl/sensor_frame_crc_temperature_top.sv
tb/sensor_frame_crc_temperature_checker.sv
tb/sensor_frame_crc_temperature_top_tb.sv
